>>> rtl/pwts_pkg.sv
package pwts_pkg;

    // Field and datapath widths.
    localparam int CoordW    = 32;   // Q16.16 coordinates and coefficients
    localparam int CfgW      = 64;   // widest configuration register
    localparam int DimW      = 14;   // viewport dimension
    localparam int AccW      = 50;   // signed row dot product
    localparam int MagW      = 48;   // magnitude of a dot product, divisor
    localparam int ProdW     = MagW + DimW;
    localparam int HalfShift = 15;   // D/2 in Q16.16 is D << 15
    localparam int QW        = 34;   // quotient bits kept before clamping
    localparam int DivSteps  = QW;   // one quotient bit per pipeline stage
    localparam int RemInitW  = ProdW - (QW - HalfShift);
    localparam int PipeLat   = DivSteps + 5;
    localparam int VisMinW   = 655;  // 0.01 in Q16.16
    localparam int OutW      = 38;   // pre-saturation screen coordinate

    typedef enum logic [2:0] {
        RegRow0Cols01   = 3'd0,
        RegRow0Cols23   = 3'd1,
        RegRow1Cols01   = 3'd2,
        RegRow1Cols23   = 3'd3,
        RegRow3Cols01   = 3'd4,
        RegRow3Cols23   = 3'd5,
        RegScreenWidth  = 3'd6,
        RegScreenHeight = 3'd7
    } cfg_idx_t;

    // Sideband that travels with an item through the divider.
    typedef struct packed {
        logic       vis;
        logic [1:0] neg;
    } div_tag_t;

    typedef struct packed {
        div_tag_t                   tag;
        logic [MagW-1:0]            w;
        logic [1:0][ProdW-1:0]      prod;
    } div_req_t;

    typedef struct packed {
        div_tag_t                   tag;
        logic [1:0]                 ovf;
        logic [1:0][QW-1:0]         quo;
    } div_rsp_t;

endpackage

>>> rtl/pwts_div.sv
// Two-lane pipelined restoring divider sharing one divisor. It forms
// floor((prod << 15) / w) one quotient bit per stage, and flags a lane whose
// quotient would reach 2^34, which always saturates downstream.
module pwts_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  pwts_pkg::div_req_t req,
    output logic               out_valid,
    output pwts_pkg::div_rsp_t rsp
);

    logic                                 valid_reg [0:pwts_pkg::DivSteps];
    pwts_pkg::div_tag_t                   tag_reg   [0:pwts_pkg::DivSteps];
    logic [pwts_pkg::MagW-1:0]            w_reg     [0:pwts_pkg::DivSteps];
    logic [1:0]                           ovf_reg   [0:pwts_pkg::DivSteps];
    logic [1:0][pwts_pkg::MagW-1:0]       rem_reg   [0:pwts_pkg::DivSteps];
    logic [1:0][pwts_pkg::QW-1:0]         num_reg   [0:pwts_pkg::DivSteps];
    logic [1:0][pwts_pkg::QW-1:0]         quo_reg   [0:pwts_pkg::DivSteps];

    logic [1:0][pwts_pkg::RemInitW-1:0]   hi_next;
    logic [1:0]                           ovf_next;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            hi_next[l]  = req.prod[l][pwts_pkg::ProdW-1:pwts_pkg::QW-pwts_pkg::HalfShift];
            ovf_next[l] = pwts_pkg::MagW'(hi_next[l]) >= req.w;
        end
    end

    // Entry stage: overflow check and initial partial remainder.
    always_ff @(posedge clk)
    begin
        tag_reg[0] <= req.tag;
        w_reg[0]   <= req.w;
        ovf_reg[0] <= ovf_next;
        for (int l = 0; l < 2; l++)
        begin
            rem_reg[0][l] <= pwts_pkg::MagW'(hi_next[l]);
            num_reg[0][l] <= {req.prod[l][pwts_pkg::QW-pwts_pkg::HalfShift-1:0],
                              pwts_pkg::HalfShift'(0)};
            quo_reg[0][l] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    for (genvar s = 1; s <= pwts_pkg::DivSteps; s++)
    begin : g_step
        logic [1:0][pwts_pkg::MagW:0]   sh_next;
        logic [1:0][pwts_pkg::MagW-1:0] rem_next;
        logic [1:0]                     ge_next;

        always_comb
        begin
            for (int l = 0; l < 2; l++)
            begin
                sh_next[l] = {rem_reg[s-1][l], num_reg[s-1][l][pwts_pkg::QW-1]};
                ge_next[l] = sh_next[l] >= {1'b0, w_reg[s-1]};
                if (ge_next[l])
                begin
                    rem_next[l] = pwts_pkg::MagW'(sh_next[l] - {1'b0, w_reg[s-1]});
                end
                else
                begin
                    rem_next[l] = sh_next[l][pwts_pkg::MagW-1:0];
                end
            end
        end

        always_ff @(posedge clk)
        begin
            tag_reg[s] <= tag_reg[s-1];
            w_reg[s]   <= w_reg[s-1];
            ovf_reg[s] <= ovf_reg[s-1];
            for (int l = 0; l < 2; l++)
            begin
                rem_reg[s][l] <= rem_next[l];
                num_reg[s][l] <= {num_reg[s-1][l][pwts_pkg::QW-2:0], 1'b0};
                quo_reg[s][l] <= {quo_reg[s-1][l][pwts_pkg::QW-2:0], ge_next[l]};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end
    end

    assign out_valid = valid_reg[pwts_pkg::DivSteps];
    assign rsp.tag   = tag_reg[pwts_pkg::DivSteps];
    assign rsp.ovf   = ovf_reg[pwts_pkg::DivSteps];
    assign rsp.quo   = quo_reg[pwts_pkg::DivSteps];

    // Lane 0 of a visible item without overflow must leave a remainder below the divisor.
    property p_rem_below_w;
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !rsp.ovf[0] && rsp.tag.vis) |->
            (rem_reg[pwts_pkg::DivSteps][0] < w_reg[pwts_pkg::DivSteps]);
    endproperty
    a_rem_below_w: assert property (p_rem_below_w)
        else $error("divider remainder not below divisor");

    // Valid advances exactly one stage per cycle through the divider.
    property p_latency;
        @(posedge clk) disable iff (!rst_n)
        in_valid |-> ##(pwts_pkg::DivSteps + 1) out_valid;
    endproperty
    a_latency: assert property (p_latency)
        else $error("divider lost an item");

    // Tag reaching the end is the one that entered with the item.
    property p_tag;
        @(posedge clk) disable iff (!rst_n)
        in_valid |-> ##(pwts_pkg::DivSteps + 1)
            (rsp.tag == $past(req.tag, pwts_pkg::DivSteps + 1));
    endproperty
    a_tag: assert property (p_tag)
        else $error("divider sideband out of step");

endmodule

>>> rtl/perspective_world_to_screen_unit.sv
// Perspective world-to-screen projection. A point is accepted on every clock
// edge at which start is high; busy is tied low, so one point may follow
// another in every cycle. The result is registered onto the outputs, marked
// by done for one cycle, and is taken at the edge that ends that cycle.
// It must be taken then: the unit has no way to hold a result back. The
// pipeline is made of the three front stages (products, row sums, viewport
// scaling), the overflow check, the 34-stage divider that yields one
// quotient bit per stage, and the final saturation stage. Matrix and
// viewport registers are read live by the pipeline, so they should be
// written only while no transaction is in flight. Points whose clip w is
// below 0.01 come out with visible low and both screen coordinates zero.
module perspective_world_to_screen_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [pwts_pkg::CoordW-1:0]  pos_x,
    input  logic signed [pwts_pkg::CoordW-1:0]  pos_y,
    input  logic signed [pwts_pkg::CoordW-1:0]  pos_z,
    input  logic                                cfg_we,
    input  logic [2:0]                          cfg_index,
    input  logic [pwts_pkg::CfgW-1:0]           cfg_data,
    output logic                                done,
    output logic                                visible,
    output logic signed [pwts_pkg::CoordW-1:0]  screen_x,
    output logic signed [pwts_pkg::CoordW-1:0]  screen_y
);

    localparam int CW = pwts_pkg::CoordW;

    // Configuration registers. Rows are held as [row][register]; row index 2
    // here stands for matrix row 3.
    logic [pwts_pkg::CfgW-1:0] coef_reg [3][2];
    logic [pwts_pkg::DimW-1:0] width_reg;
    logic [pwts_pkg::DimW-1:0] height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                coef_reg[r][0] <= '0;
                coef_reg[r][1] <= '0;
            end
            width_reg  <= pwts_pkg::DimW'(1920);
            height_reg <= pwts_pkg::DimW'(1080);
        end
        else if (cfg_we)
        begin
            case (pwts_pkg::cfg_idx_t'(cfg_index))
                pwts_pkg::RegRow0Cols01:   coef_reg[0][0] <= cfg_data;
                pwts_pkg::RegRow0Cols23:   coef_reg[0][1] <= cfg_data;
                pwts_pkg::RegRow1Cols01:   coef_reg[1][0] <= cfg_data;
                pwts_pkg::RegRow1Cols23:   coef_reg[1][1] <= cfg_data;
                pwts_pkg::RegRow3Cols01:   coef_reg[2][0] <= cfg_data;
                pwts_pkg::RegRow3Cols23:   coef_reg[2][1] <= cfg_data;
                pwts_pkg::RegScreenWidth:  width_reg  <= cfg_data[pwts_pkg::DimW-1:0];
                pwts_pkg::RegScreenHeight: height_reg <= cfg_data[pwts_pkg::DimW-1:0];
                default:                   width_reg  <= width_reg;
            endcase
        end
    end

    // The unit never refuses a transaction.
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // Stage 1: nine coefficient-by-coordinate products.
    logic                       v1_reg;
    logic signed [2*CW-1:0]     prod_reg [3][3];

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            prod_reg[r][0] <= $signed(coef_reg[r][0][CW-1:0]) * pos_x;
            prod_reg[r][1] <= $signed(coef_reg[r][0][2*CW-1:CW]) * pos_y;
            prod_reg[r][2] <= $signed(coef_reg[r][1][CW-1:0]) * pos_z;
        end
    end

    // Stage 2: floor each product to Q16.16 and add the row's constant term.
    logic                                 v2_reg;
    logic signed [pwts_pkg::AccW-1:0]     dot_reg [3];
    logic signed [pwts_pkg::AccW-1:0]     dot_next [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            dot_next[r] = pwts_pkg::AccW'(prod_reg[r][0] >>> 16)
                        + pwts_pkg::AccW'(prod_reg[r][1] >>> 16)
                        + pwts_pkg::AccW'(prod_reg[r][2] >>> 16)
                        + pwts_pkg::AccW'($signed(coef_reg[r][1][2*CW-1:CW]));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            dot_reg[r] <= dot_next[r];
        end
    end

    // Stage 3: visibility test, sign and magnitude of cx and cy, and the
    // magnitude scaled by the viewport dimension.
    logic                                   v3_reg;
    pwts_pkg::div_req_t                     req_reg;
    pwts_pkg::div_req_t                     req_next;
    logic [1:0][pwts_pkg::AccW-1:0]         mag_next;
    logic [1:0][pwts_pkg::DimW-1:0]         dim_next;

    always_comb
    begin
        dim_next[0]       = width_reg;
        dim_next[1]       = height_reg;
        req_next.tag.vis  = dot_reg[2] >= pwts_pkg::AccW'(pwts_pkg::VisMinW);
        req_next.w        = dot_reg[2][pwts_pkg::MagW-1:0];
        for (int l = 0; l < 2; l++)
        begin
            req_next.tag.neg[l] = dot_reg[l][pwts_pkg::AccW-1];
            mag_next[l] = req_next.tag.neg[l] ? -dot_reg[l] : dot_reg[l];
            req_next.prod[l] = pwts_pkg::ProdW'(mag_next[l][pwts_pkg::MagW-1:0])
                             * pwts_pkg::ProdW'(dim_next[l]);
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Division of the scaled offsets by w.
    logic               div_valid;
    pwts_pkg::div_rsp_t div_rsp;

    pwts_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .req       (req_reg),
        .out_valid (div_valid),
        .rsp       (div_rsp)
    );

    // Final stage: clamp the quotient, apply the sign, offset from the
    // viewport center and saturate to 32 bits. x grows right, y grows down.
    logic signed [pwts_pkg::OutW-1:0]  off_next  [2];
    logic signed [pwts_pkg::OutW-1:0]  base_next [2];
    logic signed [pwts_pkg::OutW-1:0]  sum_next  [2];
    logic signed [CW-1:0]              sat_next  [2];
    logic [pwts_pkg::QW-1:0]           mag_q_next [2];

    always_comb
    begin
        base_next[0] = pwts_pkg::OutW'({width_reg, pwts_pkg::HalfShift'(0)});
        base_next[1] = pwts_pkg::OutW'({height_reg, pwts_pkg::HalfShift'(0)});
        for (int l = 0; l < 2; l++)
        begin
            mag_q_next[l] = div_rsp.ovf[l] ? pwts_pkg::QW'(64'd1 << 33)
                                           : div_rsp.quo[l];
            off_next[l] = div_rsp.tag.neg[l] ? -pwts_pkg::OutW'(mag_q_next[l])
                                             : pwts_pkg::OutW'(mag_q_next[l]);
        end
        sum_next[0] = base_next[0] + off_next[0];
        sum_next[1] = base_next[1] - off_next[1];
        for (int l = 0; l < 2; l++)
        begin
            if (sum_next[l] > pwts_pkg::OutW'(64'sd2147483647))
            begin
                sat_next[l] = CW'(64'sd2147483647);
            end
            else if (sum_next[l] < -pwts_pkg::OutW'(64'sd2147483648))
            begin
                sat_next[l] = CW'(-64'sd2147483648);
            end
            else
            begin
                sat_next[l] = sum_next[l][CW-1:0];
            end
        end
    end

    logic                 done_reg;
    logic                 visible_reg;
    logic signed [CW-1:0] screen_x_reg;
    logic signed [CW-1:0] screen_y_reg;

    always_ff @(posedge clk)
    begin
        visible_reg  <= div_rsp.tag.vis;
        screen_x_reg <= div_rsp.tag.vis ? sat_next[0] : '0;
        screen_y_reg <= div_rsp.tag.vis ? sat_next[1] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid;
        end
    end

    assign done     = done_reg;
    assign visible  = visible_reg;
    assign screen_x = screen_x_reg;
    assign screen_y = screen_y_reg;

    // A hidden point always reports zero coordinates.
    property p_hidden_zero;
        @(posedge clk) disable iff (!rst_n)
        (done && !visible) |-> (screen_x == '0 && screen_y == '0);
    endproperty
    a_hidden_zero: assert property (p_hidden_zero)
        else $error("hidden point with nonzero coordinates");

    // Every accepted transaction yields a result after the fixed latency.
    property p_latency;
        @(posedge clk) disable iff (!rst_n)
        accept |-> ##(pwts_pkg::PipeLat) done;
    endproperty
    a_latency: assert property (p_latency)
        else $error("result missing after pipeline latency");

    // No result appears without a transaction accepted one latency earlier.
    property p_no_spurious;
        @(posedge clk) disable iff (!rst_n)
        !$past(accept, pwts_pkg::PipeLat) |-> !done;
    endproperty
    a_no_spurious: assert property (p_no_spurious)
        else $error("result without a matching transaction");

endmodule
